@@ hw/rtl/ets_pkg.sv @@
// Shared constants, request codes and controller/datapath types for the event timer.
`timescale 1ns / 1ps

package ets_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MASK_EXT_W   = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;

    localparam int REQ_TYPE_W = 2;
    localparam int CHANNEL_W  = 3;
    localparam int TIME_W     = 32;
    localparam int FIRED_W    = 8;

    localparam logic [REQ_TYPE_W-1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FIRE     = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_ADVANCE  = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ets_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_free;
    } ets_stat_t;

endpackage

@@ hw/rtl/ets_req_if.sv @@
// Request channel interface: valid/ready plus the request payload.
`timescale 1ns / 1ps

interface ets_req_if;
    logic                             valid;
    logic                             ready;
    logic [ets_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [ets_pkg::CHANNEL_W-1:0]    channel;
    logic [ets_pkg::TIME_W-1:0]       cycles;

    modport source (output valid, output req_type, output channel, output cycles,
                    input ready);
    modport sink   (input valid, input req_type, input channel, input cycles,
                    output ready);
endinterface

@@ hw/rtl/ets_rsp_if.sv @@
// Response channel interface: valid/ready plus the result payload.
`timescale 1ns / 1ps

interface ets_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ets_pkg::FIRED_W-1:0]   fired_mask;
    logic [ets_pkg::TIME_W-1:0]    step_cycles;
    logic [ets_pkg::TIME_W-1:0]    now_count;

    modport source (output valid, output fired_mask, output step_cycles,
                    output now_count, input ready);
    modport sink   (input valid, input fired_mask, input step_cycles,
                    input now_count, output ready);
endinterface

@@ hw/rtl/ets_ctrl.sv @@
// Controller state machine: accept, channel scan and result commit sequencing.
`timescale 1ns / 1ps

module ets_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ets_pkg::ets_stat_t stat,
    output ets_pkg::ets_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.needs_scan ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // wait for the output register to free up
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/ets_datapath.sv @@
// Datapath: counter, active mask, due times, scan unit and output register.
`timescale 1ns / 1ps

module ets_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ets_pkg::ets_cmd_t               cmd,
    output ets_pkg::ets_stat_t              stat,
    input  logic [ets_pkg::REQ_TYPE_W-1:0]  in_req_type,
    input  logic [ets_pkg::CHANNEL_W-1:0]   in_channel,
    input  logic [ets_pkg::TIME_W-1:0]      in_cycles,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ets_pkg::FIRED_W-1:0]     out_fired_mask,
    output logic [ets_pkg::TIME_W-1:0]      out_step_cycles,
    output logic [ets_pkg::TIME_W-1:0]      out_now_count
);

    localparam int NCH = ets_pkg::NUM_CHANNELS;
    localparam int IW  = ets_pkg::CH_IDX_W;
    localparam int TW  = ets_pkg::TIME_W;

    logic [TW-1:0]         now_reg;
    logic [NCH-1:0]        active_reg;
    logic [TW-1:0]         due_reg [NCH];
    logic [ets_pkg::REQ_TYPE_W-1:0] op_reg;
    logic [IW-1:0]         idx_reg;
    logic [NCH-1:0]        hits_reg;
    logic [TW-1:0]         best_reg;

    logic                  out_valid_reg;
    logic [ets_pkg::FIRED_W-1:0] fired_reg;
    logic [TW-1:0]         step_reg;
    logic [TW-1:0]         now_out_reg;

    logic                  ch_in_range;
    logic [IW-1:0]         wr_idx;
    logic [TW-1:0]         cur_due;
    logic [TW-1:0]         due_gap;
    logic                  cur_active;
    logic [ets_pkg::MASK_EXT_W-1:0] hits_ext;
    logic [TW-1:0]         now_next;
    logic [TW-1:0]         step_val;

    assign ch_in_range = (32'(in_channel) < NCH);
    assign wr_idx      = IW'(in_channel);
    assign cur_due     = due_reg[idx_reg];
    assign cur_active  = active_reg[idx_reg];
    assign due_gap     = cur_due - now_reg;
    assign hits_ext    = ets_pkg::MASK_EXT_W'(hits_reg);
    assign step_val    = (op_reg == ets_pkg::REQ_ADVANCE) ? best_reg : '0;
    assign now_next    = now_reg + step_val;

    assign stat.needs_scan = (in_req_type == ets_pkg::REQ_FIRE) ||
                             (in_req_type == ets_pkg::REQ_ADVANCE);
    assign stat.scan_last  = (idx_reg == IW'(NCH - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    // control state: counter, active mask, scan index, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            active_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                if (in_req_type == ets_pkg::REQ_SCHEDULE && ch_in_range)
                begin
                    active_reg[wr_idx] <= 1'b1;
                end
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.commit)
            begin
                now_reg       <= now_next;
                out_valid_reg <= 1'b1;
                if (op_reg == ets_pkg::REQ_FIRE)
                begin
                    active_reg <= active_reg & ~hits_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_req_type;
            best_reg <= in_cycles;
            hits_reg <= '0;
            if (in_req_type == ets_pkg::REQ_SCHEDULE && ch_in_range)
            begin
                due_reg[wr_idx] <= now_reg + in_cycles;
            end
        end
        else if (cmd.scan_step && cur_active)
        begin
            if (cur_due == now_reg)
            begin
                hits_reg[idx_reg] <= 1'b1;
            end
            if (due_gap < best_reg)
            begin
                best_reg <= due_gap;
            end
        end

        if (cmd.commit)
        begin
            fired_reg   <= (op_reg == ets_pkg::REQ_FIRE) ? hits_ext[7:0] : '0;
            step_reg    <= step_val;
            now_out_reg <= now_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_fired_mask  = fired_reg;
    assign out_step_cycles = step_reg;
    assign out_now_count   = now_out_reg;

endmodule

@@ hw/rtl/event_timer_scheduler_unit.sv @@
// Top level of the multi-channel event timer: controller, datapath and assertions.
`timescale 1ns / 1ps

// Channel  Dir  Payload                                  Transfer when
// req      in   req_type[1:0], channel[2:0], cycles[31:0]   req.valid && req.ready
// rsp      out  fired_mask[7:0], step_cycles[31:0],        rsp.valid && rsp.ready
//               now_count[31:0]
//
// Schedule and unused codes skip the scan: the controller goes from the transfer
// straight to its hold state, where the result register loads. Fire and advance
// first run the one-channel-per-cycle scan over the due-time registers, then
// reach the hold state; in both cases the load waits for a free output register.
// One request is in flight at a time; a new request transfers while the
// previous result still waits in the output register.
// A stalled rsp holds the result; a finished item waits in its hold state.
// Reset clears the counter, active mask, controller and output valid; due
// times are written before they are ever read.

module event_timer_scheduler_unit (
    input  logic      clk,
    input  logic      rst_n,
    ets_req_if.sink   req,
    ets_rsp_if.source rsp
);

    ets_pkg::ets_cmd_t  cmd;
    ets_pkg::ets_stat_t stat;

    // sequence each request: accept, scan channels, commit the result
    ets_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold timer state and compute fire hits / next-event distance
    ets_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_req_type     (req.req_type),
        .in_channel      (req.channel),
        .in_cycles       (req.cycles),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_fired_mask  (rsp.fired_mask),
        .out_step_cycles (rsp.step_cycles),
        .out_now_count   (rsp.now_count)
    );

`ifndef ASSERT_OFF
    // a commit always lands in a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("commit into occupied output register");

    // a committed result is presented next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed result not presented");

    // the block is busy right after it takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous one still in flight");
`endif

endmodule
